>>> rtl/turret_bearing_and_range_macros.svh
// Assertion macros for the turret bearing and range controller
`ifndef TURRET_BEARING_AND_RANGE_MACROS_SVH
`define TURRET_BEARING_AND_RANGE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define TBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tbr_pkg.sv
// Types, constants and the arctangent step table for turret bearing and range
package tbr_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 2'd1;

  localparam int SQRT_STEPS = 17;
  localparam int VEC_W      = 44;
  localparam int ANG_W      = 24;
  localparam int SQ_W       = 35;

  localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = 24'sd2949120;
  localparam logic signed [17:0] HALF_TURN  = 18'sd11520;
  localparam logic signed [17:0] FULL_TURN  = 18'sd23040;
  localparam logic signed [17:0] TRAVEL_MAX = 18'sd11488;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INIT,
    ST_ITER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic init;
    logic iter;
    logic finish;
  } cmd_t;

  // atan(2^-i) in 2^-14 degree
  function automatic logic signed [ANG_W-1:0] step_angle(input logic [4:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      5'd0:  a = 24'sd737280;
      5'd1:  a = 24'sd435242;
      5'd2:  a = 24'sd229970;
      5'd3:  a = 24'sd116736;
      5'd4:  a = 24'sd58595;
      5'd5:  a = 24'sd29326;
      5'd6:  a = 24'sd14667;
      5'd7:  a = 24'sd7334;
      5'd8:  a = 24'sd3667;
      5'd9:  a = 24'sd1833;
      5'd10: a = 24'sd917;
      5'd11: a = 24'sd458;
      5'd12: a = 24'sd229;
      5'd13: a = 24'sd115;
      5'd14: a = 24'sd57;
      5'd15: a = 24'sd29;
      5'd16: a = 24'sd14;
      5'd17: a = 24'sd7;
      5'd18: a = 24'sd4;
      5'd19: a = 24'sd2;
      5'd20: a = 24'sd1;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/turret_bearing_and_range.sv
// Top level: turret bearing and range to a configured target
// Usage:
//   Input channel (in_valid/in_stall) takes one turret pose: x, y in 1/1024 m
//   and heading in 1/64 degree. The result channel (out_valid/out_stall)
//   returns the bearing to the target relative to the heading, folded into
//   plus/minus 179.5 degrees, and the rounded range, saturated at 65535.
//   The target position is written over the cfg_ port (index 0 = x,
//   index 1 = y); cfg_ready is always high, other indexes are ignored.
//   One pose is worked at a time: load, square, setup, then
//   max(CORDIC_STEPS, 17) iterations of the shared CORDIC and square-root
//   step, then a final step to fold and register the result. With the
//   default of 16 steps, a new item is taken in the cycle after the result
//   is registered. The iteration count of the CORDIC / square-root unit
//   sets how long each item takes.
//   Reset clears the target registers and the stored last bearing to zero.
//   While the receiver stalls, the result holds; the next pose may still be
//   accepted and worked, and waits at its end until the output frees.
module turret_bearing_and_range #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_turret_x,
  input  logic signed [15:0]            in_turret_y,
  input  logic signed [14:0]            in_turret_heading,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [14:0]            out_bearing,
  output logic [15:0]                   out_range,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import tbr_pkg::*;

  localparam int ITERS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int CNT_W = $clog2(ITERS);

  cmd_t              cmd;
  logic [CNT_W-1:0]  step;

  assign cfg_ready = 1'b1;

  tbr_ctrl #(
    .ITERS (ITERS),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .step      (step)
  );

  tbr_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .CNT_W        (CNT_W)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .step              (step),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_turret_x       (in_turret_x),
    .in_turret_y       (in_turret_y),
    .in_turret_heading (in_turret_heading),
    .out_bearing       (out_bearing),
    .out_range         (out_range)
  );

endmodule

>>> rtl/tbr_ctrl.sv
// Controller state machine sequencing one pose through the datapath
`include "turret_bearing_and_range_macros.svh"

module tbr_ctrl #(
  parameter int ITERS = 17,
  parameter int CNT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tbr_pkg::cmd_t     cmd,
  output logic [CNT_W-1:0]  step
);
  import tbr_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State, counter and result flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (cnt_r == CNT_W'(ITERS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign step      = cnt_r;

  `TBR_ASSERT_NXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_r,
    "finished item not presented")
  `TBR_ASSERT_IMP(a_finish_free, clk, rst_n, cmd.finish, !out_valid_r || !out_stall,
    "result overwritten while stalled")
  `TBR_ASSERT_NXT(a_iter_end, clk, rst_n,
    state_r == ST_ITER && cnt_r == CNT_W'(ITERS - 1), state_r == ST_DONE,
    "iteration did not end")

endmodule

>>> rtl/tbr_datapath.sv
// Datapath: differences, squares, CORDIC vectoring, square root and bearing fold
module tbr_datapath #(
  parameter int CORDIC_STEPS = 16,
  parameter int CNT_W        = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tbr_pkg::cmd_t                     cmd,
  input  logic [CNT_W-1:0]                  step,
  input  logic                              cfg_valid,
  input  logic [tbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data,
  input  logic signed [15:0]                in_turret_x,
  input  logic signed [15:0]                in_turret_y,
  input  logic signed [14:0]                in_turret_heading,
  output logic signed [14:0]                out_bearing,
  output logic [15:0]                       out_range
);
  import tbr_pkg::*;

  logic signed [15:0]       target_x_r, target_y_r;
  logic signed [14:0]       last_bearing_r;
  logic signed [16:0]       dx_r, dy_r;
  logic signed [14:0]       head_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic signed [VEC_W-1:0]  x_r, y_r;
  logic signed [ANG_W-1:0]  z_r;
  logic                     zero_r;
  logic [SQ_W-1:0]          rem_r, root_r;
  logic signed [14:0]       bearing_r;
  logic [15:0]              range_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r <= '0;
      target_y_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_X: target_x_r <= cfg_data;
        REG_TARGET_Y: target_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // CORDIC start vector
  logic signed [VEC_W-1:0] x0, y0;
  assign x0 = {{(VEC_W - 41){dx_r[16]}}, dx_r, 24'b0};
  assign y0 = {{(VEC_W - 41){dy_r[16]}}, dy_r, 24'b0};

  // CORDIC step
  logic signed [VEC_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] ang;
  logic                    cordic_on, sqrt_on;
  assign xs        = x_r >>> step;
  assign ys        = y_r >>> step;
  assign ang       = step_angle(5'(step));
  assign cordic_on = int'(step) < CORDIC_STEPS;
  assign sqrt_on   = int'(step) < SQRT_STEPS;

  // Square root digit
  logic [5:0]      bit_sh;
  logic [SQ_W-1:0] sq_bit, trial;
  assign bit_sh = 6'(2 * (SQRT_STEPS - 1) - 2 * int'(step));
  assign sq_bit = SQ_W'(1) << bit_sh;
  assign trial  = root_r + sq_bit;

  // Bearing fold and range rounding
  logic signed [ANG_W-1:0] z_rnd;
  logic signed [17:0]      angle, b, r, w;
  logic signed [14:0]      w_sat;
  logic [SQ_W-1:0]         root_rnd;
  always_comb begin
    z_rnd = (z_r + ANG_W'(128)) >>> 8;
    angle = zero_r ? 18'sd0 : 18'(z_rnd);
    b     = angle - 18'(head_r);
    r     = b + HALF_TURN;
    if (r < 0) begin
      r = r + FULL_TURN;
    end else if (r >= FULL_TURN) begin
      r = r - FULL_TURN;
    end
    w = r - HALF_TURN;
    if (w > TRAVEL_MAX || w < -TRAVEL_MAX) begin
      w_sat = last_bearing_r[14] ? -15'(TRAVEL_MAX) : 15'(TRAVEL_MAX);
    end else begin
      w_sat = 15'(w);
    end
    root_rnd = root_r + SQ_W'(rem_r > root_r);
  end

  // Last bearing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_bearing_r <= '0;
    end else if (cmd.finish) begin
      last_bearing_r <= w_sat;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r   <= 17'(target_x_r) - 17'(in_turret_x);
      dy_r   <= 17'(target_y_r) - 17'(in_turret_y);
      head_r <= in_turret_heading;
    end
    if (cmd.square) begin
      sqx_r <= SQ_W'(unsigned'(34'(dx_r) * 34'(dx_r)));
      sqy_r <= SQ_W'(unsigned'(34'(dy_r) * 34'(dy_r)));
    end
    if (cmd.init) begin
      rem_r  <= sqx_r + sqy_r;
      root_r <= '0;
      zero_r <= (dx_r == '0) && (dy_r == '0);
      if (dx_r[16]) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= dy_r[16] ? -ANG_HALF_TURN : ANG_HALF_TURN;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end
    if (cmd.iter) begin
      if (cordic_on) begin
        if (!y_r[VEC_W-1]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + ang;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - ang;
        end
      end
      if (sqrt_on) begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + sq_bit;
        end else begin
          root_r <= root_r >> 1;
        end
      end
    end
    if (cmd.finish) begin
      bearing_r <= w_sat;
      range_r   <= (root_rnd > SQ_W'(65535)) ? 16'hFFFF : 16'(root_rnd);
    end
  end

  assign out_bearing = bearing_r;
  assign out_range   = range_r;

endmodule

>>> tb/sv/bearing_range_checker.sv
// Checker for turret bearing and range: tracks target registers, predicts and compares results
module bearing_range_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [15:0]            in_turret_x,
  input  logic signed [15:0]            in_turret_y,
  input  logic signed [14:0]            in_turret_heading,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [14:0]            out_bearing,
  input  logic [15:0]                   out_range,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending_count,
  output int                            result_count,
  output int                            dead_zone_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tbr_pkg::*;

  typedef struct {
    logic signed [14:0] bearing;
    logic [15:0]        range;
  } aim_t;

  // atan(2^-i) in 2^-14 degree
  localparam longint ATAN_STEP [24] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  logic signed [15:0] aim_x;
  logic signed [15:0] aim_y;
  longint             prev_bearing;
  aim_t               aim_queue[$];

  // Vectoring CORDIC: angle of (dx, dy) in 1/64 degree
  function automatic longint vector_angle(input longint dx, input longint dy);
    longint x, y, z, xs, ys;
    x = dx * 64'sd16777216;
    y = dy * 64'sd16777216;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd2949120 : -64'sd2949120;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end
    end
    return (z + 128) >>> 8;
  endfunction

  // Integer square root rounded to nearest
  function automatic longint nearest_root(input longint s);
    longint root, b;
    root = 0;
    b = 64'sd1 <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= root + b) begin
        s = s - (root + b);
        root = (root >>> 1) + b;
      end else begin
        root = root >>> 1;
      end
      b = b >>> 2;
    end
    if (s > root) root = root + 1;
    return root;
  endfunction

  assign pending_count = aim_queue.size();

  always_ff @(posedge clk) begin
    longint dx, dy, b, r, rng;
    aim_t   exp_aim;
    if (!rst_n) begin
      aim_x <= '0;
      aim_y <= '0;
      prev_bearing = 0;
      aim_queue.delete();
      fail_count <= 0;
      result_count <= 0;
      dead_zone_count <= 0;
    end else begin
      // track target registers
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TARGET_X) aim_x <= cfg_data;
        else if (cfg_index == REG_TARGET_Y) aim_y <= cfg_data;
      end
      // predict one result per accepted pose
      if (in_valid && !in_stall) begin
        dx = longint'(aim_x) - longint'(in_turret_x);
        dy = longint'(aim_y) - longint'(in_turret_y);
        b = vector_angle(dx, dy) - longint'(in_turret_heading);
        r = (b + 11520) % 23040;
        if (r < 0) r = r + 23040;
        r = r - 11520;
        if (r > 11488 || r < -11488) begin
          r = (prev_bearing >= 0) ? 11488 : -11488;
          dead_zone_count <= dead_zone_count + 1;
        end
        prev_bearing = r;
        rng = nearest_root(dx * dx + dy * dy);
        if (rng > 65535) rng = 65535;
        exp_aim.bearing = r[14:0];
        exp_aim.range = rng[15:0];
        aim_queue.push_back(exp_aim);
      end
      // compare accepted results against oldest prediction
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (aim_queue.size() == 0) begin
          $error("unexpected result: bearing %0d range %0d", out_bearing, out_range);
          fail_count <= fail_count + 1;
        end else begin
          exp_aim = aim_queue.pop_front();
          if (out_bearing !== exp_aim.bearing || out_range !== exp_aim.range) begin
            if (out_bearing !== exp_aim.bearing)
              $error("bearing: expected %0d, actual %0d", exp_aim.bearing, out_bearing);
            if (out_range !== exp_aim.range)
              $error("range: expected %0d, actual %0d", exp_aim.range, out_range);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the turret bearing and range testbench: stimulus, idling phases and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tbr_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [15:0]   in_turret_x;
  logic signed [15:0]   in_turret_y;
  logic signed [14:0]   in_turret_heading;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [14:0]   out_bearing;
  logic [15:0]          out_range;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  int fail_count, pending_count, result_count, dead_zone_count;
  int send_idle_pct, stall_pct, quiet_cycles, item_count;

  turret_bearing_and_range u_dut (.*);

  bearing_range_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random receiver stall
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("turret_bearing_and_range verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                           input logic [14:0] hd);
    bit took;
    @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_turret_x <= px;
    in_turret_y <= py;
    in_turret_heading <= hd;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    in_valid <= 1'b0;
    item_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    bit took;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  // hold until every predicted result has arrived, then let the block settle
  task automatic drain();
    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_pose(input logic [15:0] tx, input logic [15:0] ty);
    logic [15:0] px, py;
    logic [14:0] hd;
    case ($urandom_range(3))
      0: begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      1: begin
        // near the target: small offsets
        px = tx + 16'($signed($urandom_range(64)) - 32);
        py = ty + 16'($signed($urandom_range(64)) - 32);
      end
      default: begin
        px = tx + 16'($signed($urandom_range(8000)) - 4000);
        py = ty + 16'($signed($urandom_range(8000)) - 4000);
      end
    endcase
    if ($urandom_range(9) == 0) hd = 15'($urandom);
    else hd = 15'($signed($urandom_range(23039)) - 11520);
    send_pose(px, py, hd);
  endtask

  initial begin
    logic [15:0] tx, ty;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_turret_x = '0;
    in_turret_y = '0;
    in_turret_heading = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    item_count = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: target at reset value of zero
    send_pose(16'sd0, 16'sd0, 15'sd0);            // target on turret
    send_pose(16'sd100, 16'sd0, 15'sd0);          // straight behind: dead zone
    send_pose(16'sd100, 16'sd1, 15'sd0);
    send_pose(-16'sd100, 16'sd0, 15'sd0);
    send_pose(-16'sd32768, -16'sd32768, 15'sd16383);  // heading out of range
    send_pose(16'sd32767, 16'sd32767, -15'sd16384);
    send_pose(16'sd0, -16'sd500, 15'sd11519);
    send_pose(16'sd0, 16'sd500, -15'sd11520);
    drain();
    // extremes, some with a saturated range
    write_reg(REG_TARGET_X, 16'h7fff);
    write_reg(REG_TARGET_Y, 16'h7fff);
    write_reg(2'd2, 16'h1234);                    // unused index, ignored
    write_reg(2'd3, 16'hffff);
    send_pose(-16'sd32768, -16'sd32768, 15'sd0);
    send_pose(-16'sd32768, 16'sd32767, 15'sd0);
    send_pose(16'sd32767, 16'sd32767, 15'sd0);
    send_pose(16'sd32767, -16'sd32768, 15'sd5760);
    drain();
    write_reg(REG_TARGET_X, 16'h8000);
    write_reg(REG_TARGET_Y, 16'h8000);
    send_pose(16'sd32767, 16'sd32767, -15'sd5760);
    send_pose(16'sd32767, -16'sd32768, 15'sd0);
    send_pose(-16'sd32767, -16'sd32768, 15'sd0);   // behind, last bearing negative
    send_pose(-16'sd32767, -16'sd32768, 15'sd0);
    drain();

    // random: phases over target settings and idling modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin tx = 16'h0000; ty = 16'h0000; end
        1: begin tx = 16'h7fff; ty = 16'h8000; end
        2: begin tx = 16'h8000; ty = 16'h7fff; end
        default: begin tx = 16'($urandom); ty = 16'($urandom); end
      endcase
      write_reg(REG_TARGET_X, tx);
      write_reg(REG_TARGET_Y, ty);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (216) random_pose(tx, ty);
      drain();
      stall_pct = 0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d poses and %0d results over 8 target settings and four idling modes",
             item_count, result_count);
    $display("dead zone saturations: %0d", dead_zone_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("turret_bearing_and_range verification clean");
    end else begin
      $display("turret_bearing_and_range verification failed");
    end
    $finish;
  end

endmodule
